>>> design/csv_pkg.sv
// Package for the cube sphere vertex generator: field widths, register
// indexes, reset values, face codes and parameter defaults.
// No dependencies; compile before every other design file.
package csv_pkg;

    localparam int FACE_W     = 3;
    localparam int RES_REG_W  = 11;
    localparam int RADIUS_W   = 24;
    localparam int POS_W      = 25;
    localparam int NORM_W     = 16;
    localparam int CELL_W     = 10;
    localparam int INDEX_W    = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int MAX_RESOLUTION_DEF   = 1024;
    localparam int NORMAL_FRAC_BITS_DEF = 15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_RES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_RES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [RES_REG_W-1:0] MESH_RES_RST = 11'd32;
    localparam logic [RES_REG_W-1:0] GRID_RES_RST = 11'd32;
    localparam logic [RADIUS_W-1:0]  RADIUS_RST   = 24'd1000;

    // Cube face codes.
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

endpackage

>>> design/csv_ifs.sv
// Channel interfaces of the cube sphere vertex generator: configuration
// writes, grid point items and vertex items. Depends on csv_pkg.
interface csv_cfg_if
    import csv_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface csv_in_if
    import csv_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [FACE_W-1:0]    face;
    logic [RES_REG_W-1:0] grid_u;
    logic [RES_REG_W-1:0] grid_v;

    modport source (output valid, face, grid_u, grid_v, input ready);
    modport sink   (input valid, face, grid_u, grid_v, output ready);
endinterface

interface csv_out_if
    import csv_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [CELL_W-1:0]        cell_u;
    logic [CELL_W-1:0]        cell_v;
    logic [INDEX_W-1:0]       vertex_index;
    logic                     quad_corner;

    modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    cell_u, cell_v, vertex_index, quad_corner, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    cell_u, cell_v, vertex_index, quad_corner, output ready);
endinterface

>>> design/csv_isqrt_pipe.sv
// Pipelined square root of a quotient: x = floor(sqrt(r / s)), one result bit
// per register stage, using shifts and adds only. Depends on nothing.
module csv_isqrt_pipe #(
    parameter int R_W   = 72,
    parameter int S_W   = 22,
    parameter int X_W   = 25,
    parameter int DEPTH = 25
)(
    input  logic           clk,
    input  logic           en,
    input  logic [R_W-1:0] r,
    input  logic [S_W-1:0] s,
    output logic [X_W-1:0] x
);

    localparam int D_W = 2 * X_W + S_W + 2;
    localparam int P_W = X_W + S_W;

    // e holds r - x*x*s, p holds x*s for the bits found so far.
    logic [D_W-1:0] e_reg [DEPTH];
    logic [P_W-1:0] p_reg [DEPTH];
    logic [X_W-1:0] x_reg [DEPTH];
    logic [S_W-1:0] s_reg [DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_stage
            logic [D_W-1:0] e_in;
            logic [P_W-1:0] p_in;
            logic [X_W-1:0] x_in;
            logic [S_W-1:0] s_in;
            logic [D_W-1:0] e_next;
            logic [P_W-1:0] p_next;
            logic [X_W-1:0] x_next;

            if (k == 0) begin : g_first
                assign e_in = D_W'(r);
                assign p_in = '0;
                assign x_in = '0;
                assign s_in = s;
            end
            else begin : g_rest
                assign e_in = e_reg[k-1];
                assign p_in = p_reg[k-1];
                assign x_in = x_reg[k-1];
                assign s_in = s_reg[k-1];
            end

            if (k < X_W) begin : g_bit
                localparam int B = X_W - 1 - k;
                logic [D_W-1:0] d;

                always_comb
                begin
                    // (x + 2^B)^2 s - x^2 s = 2^(B+1) x s + 2^(2B) s
                    d = (D_W'(p_in) << (B + 1)) + (D_W'(s_in) << (2 * B));
                    if (e_in >= d)
                    begin
                        e_next = e_in - d;
                        p_next = p_in + (P_W'(s_in) << B);
                        x_next = x_in | (X_W'(1) << B);
                    end
                    else
                    begin
                        e_next = e_in;
                        p_next = p_in;
                        x_next = x_in;
                    end
                end
            end
            else begin : g_pass
                assign e_next = e_in;
                assign p_next = p_in;
                assign x_next = x_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    e_reg[k] <= e_next;
                    p_reg[k] <= p_next;
                    x_reg[k] <= x_next;
                    s_reg[k] <= s_in;
                end
            end
        end
    endgenerate

    assign x = x_reg[DEPTH-1];

endmodule

>>> design/cube_sphere_vertex_generator.sv
// Top level of the cube sphere vertex generator: maps grid points of a cube
// face onto a sphere. Depends on csv_pkg, csv_ifs and csv_isqrt_pipe.
//
// Usage:
// The cfg channel writes the registers mesh_resolution (index 0),
// grid_resolution (index 1) and sphere_radius (index 2); its ready is always
// high and writes are meant to happen only while no item is in flight.
// The grid_pt channel takes one item per grid point (face, grid_u, grid_v).
// The vertex channel returns one item per grid point, in order: position,
// Q1.15 unit normal, simulation cell, linear vertex index and quad flag.
// The pipeline takes a new item every cycle unless the output stalls. An
// item passes stages 1 to 4, the square root lanes and the output register.
// The lane depth LD is the largest of radius width + 1, NORMAL_FRAC_BITS + 2
// and the resolution width, as the bit-serial lanes find one result bit per stage.
// Reset clears all valid bits and loads the register reset values
// (32, 32, 1000). When the receiver holds ready low while an item waits at
// the output register, the whole pipeline freezes and grid_pt.ready drops;
// nothing is lost or repeated, and flow resumes as soon as ready returns.
module cube_sphere_vertex_generator
    import csv_pkg::*;
#(
    parameter int MAX_RESOLUTION   = MAX_RESOLUTION_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    csv_cfg_if.sink   cfg,
    csv_in_if.sink    grid_pt,
    csv_out_if.source vertex
);

    localparam int F      = NORMAL_FRAC_BITS;
    localparam int MAG_W  = $clog2(MAX_RESOLUTION + 1);
    localparam int C_W    = MAG_W + 1;
    localparam int ROW_W  = MAG_W + 1;
    localparam int S_W    = 2 * MAG_W + 2;
    localparam int MK_W   = MAG_W + RADIUS_W;
    localparam int SPLIT  = (MK_W + 1) / 2;
    localparam int HI_W   = MK_W - SPLIT;
    localparam int RP_W   = 2 * MK_W + 2;
    localparam int RN_W   = 2 * MAG_W + 2 * F + 2;
    localparam int XP_W   = RADIUS_W + 1;
    localparam int XN_W   = F + 2;
    localparam int DV_W   = 2 * MAG_W;
    localparam int IDXF_W = FACE_W + 2 * ROW_W + 1;
    localparam int LD_A   = (XP_W > XN_W) ? XP_W : XN_W;
    localparam int LD     = (LD_A > MAG_W) ? LD_A : MAG_W;
    localparam int TOT    = LD + 5;
    localparam int NMAX   = (1 << F) - 1;

    // ------------------------------------------------------------------
    // Configuration registers and their clamped working values.
    // ------------------------------------------------------------------
    logic [RES_REG_W-1:0] mesh_res_reg;
    logic [RES_REG_W-1:0] grid_res_reg;
    logic [RADIUS_W-1:0]  radius_reg;
    logic [MAG_W-1:0]     res_eff;
    logic [MAG_W-1:0]     grid_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_res_reg <= MESH_RES_RST;
            grid_res_reg <= GRID_RES_RST;
            radius_reg   <= RADIUS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MESH_RES: mesh_res_reg <= cfg.data[RES_REG_W-1:0];
                CFG_GRID_RES: grid_res_reg <= cfg.data[RES_REG_W-1:0];
                CFG_RADIUS:   radius_reg   <= cfg.data[RADIUS_W-1:0];
                default:      ;
            endcase
        end
    end

    // A resolution of zero acts as one; one beyond the maximum saturates.
    always_comb
    begin
        if (mesh_res_reg == '0)
            res_eff = MAG_W'(1);
        else if (int'(mesh_res_reg) > MAX_RESOLUTION)
            res_eff = MAG_W'(MAX_RESOLUTION);
        else
            res_eff = MAG_W'(mesh_res_reg);

        if (grid_res_reg == '0)
            grid_eff = MAG_W'(1);
        else if (int'(grid_res_reg) > MAX_RESOLUTION)
            grid_eff = MAG_W'(MAX_RESOLUTION);
        else
            grid_eff = MAG_W'(grid_res_reg);
    end

    // ------------------------------------------------------------------
    // Flow control. All stages move together; the pipeline only stops
    // when a finished item sits in the output register and is not taken.
    // ------------------------------------------------------------------
    logic [TOT-1:0] vld_reg;
    logic           en;

    assign en            = !vld_reg[TOT-1] || vertex.ready;
    assign grid_pt.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOT-2:0], grid_pt.valid};
    end

    // ------------------------------------------------------------------
    // Entry: clamp the grid point and build the scaled cube point
    // c = N*res + A*(2u - res) + B*(2v - res) from the face axes.
    // ------------------------------------------------------------------
    logic [FACE_W-1:0]     face_c;
    logic [MAG_W-1:0]      u_c;
    logic [MAG_W-1:0]      v_c;
    logic signed [C_W-1:0] du;
    logic signed [C_W-1:0] dv;
    logic signed [C_W-1:0] pres;
    logic signed [C_W-1:0] c_next [3];

    always_comb
    begin
        // Faces six and seven fold onto the -Z face.
        face_c = (grid_pt.face > FACE_NEG_Z) ? FACE_NEG_Z : grid_pt.face;
        u_c = (int'(grid_pt.grid_u) > int'(res_eff)) ? res_eff : MAG_W'(grid_pt.grid_u);
        v_c = (int'(grid_pt.grid_v) > int'(res_eff)) ? res_eff : MAG_W'(grid_pt.grid_v);
        du   = C_W'($signed({1'b0, u_c, 1'b0}) - $signed({2'b00, res_eff}));
        dv   = C_W'($signed({1'b0, v_c, 1'b0}) - $signed({2'b00, res_eff}));
        pres = $signed({1'b0, res_eff});
        case (face_c)
            FACE_POS_X: begin c_next[0] = pres;  c_next[1] = du;    c_next[2] = dv;    end
            FACE_NEG_X: begin c_next[0] = -pres; c_next[1] = -du;   c_next[2] = dv;    end
            FACE_POS_Y: begin c_next[0] = -du;   c_next[1] = pres;  c_next[2] = dv;    end
            FACE_NEG_Y: begin c_next[0] = du;    c_next[1] = -pres; c_next[2] = dv;    end
            FACE_POS_Z: begin c_next[0] = du;    c_next[1] = dv;    c_next[2] = pres;  end
            default:    begin c_next[0] = du;    c_next[1] = -dv;   c_next[2] = -pres; end
        endcase
    end

    // Stage 1 registers.
    logic [FACE_W-1:0]     face1_reg;
    logic [MAG_W-1:0]      u1_reg;
    logic [MAG_W-1:0]      v1_reg;
    logic signed [C_W-1:0] c1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face1_reg <= face_c;
            u1_reg    <= u_c;
            v1_reg    <= v_c;
            c1_reg    <= c_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes and signs, squares, magnitude times radius, and
    // the products for the vertex index and the cell numerators.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]   mag [3];
    logic [2:0]         neg2_next;
    logic [DV_W-1:0]    sq2_next [3];
    logic [MK_W-1:0]    mk2_next [3];
    logic [ROW_W-1:0]   row;
    logic [2*ROW_W-1:0] row2_next;
    logic [2*ROW_W-1:0] vr2_next;
    logic [DV_W-1:0]    nu2_next;
    logic [DV_W-1:0]    nv2_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg2_next[i] = c1_reg[i][C_W-1];
            mag[i] = c1_reg[i][C_W-1] ? MAG_W'(-c1_reg[i]) : MAG_W'(c1_reg[i]);
            sq2_next[i] = DV_W'(mag[i]) * DV_W'(mag[i]);
            mk2_next[i] = MK_W'(mag[i]) * MK_W'(radius_reg);
        end
        row       = ROW_W'(res_eff) + ROW_W'(1);
        row2_next = (2*ROW_W)'(row) * (2*ROW_W)'(row);
        vr2_next  = (2*ROW_W)'(v1_reg) * (2*ROW_W)'(row);
        nu2_next  = DV_W'(u1_reg) * DV_W'(grid_eff);
        nv2_next  = DV_W'(v1_reg) * DV_W'(grid_eff);
    end

    logic [FACE_W-1:0]  face2_reg;
    logic [MAG_W-1:0]   u2_reg;
    logic [MAG_W-1:0]   v2_reg;
    logic [2:0]         neg2_reg;
    logic [DV_W-1:0]    sq2_reg [3];
    logic [MK_W-1:0]    mk2_reg [3];
    logic [2*ROW_W-1:0] row2_reg;
    logic [2*ROW_W-1:0] vr2_reg;
    logic [DV_W-1:0]    nu2_reg;
    logic [DV_W-1:0]    nv2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face2_reg <= face1_reg;
            u2_reg    <= u1_reg;
            v2_reg    <= v1_reg;
            neg2_reg  <= neg2_next;
            sq2_reg   <= sq2_next;
            mk2_reg   <= mk2_next;
            row2_reg  <= row2_next;
            vr2_reg   <= vr2_next;
            nu2_reg   <= nu2_next;
            nv2_reg   <= nv2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared length, partial products of (mag*radius)^2, the
    // linear vertex index and the quad corner flag.
    // ------------------------------------------------------------------
    logic [S_W-1:0]     s3_next;
    logic [2*HI_W-1:0]  hh3_next [3];
    logic [MK_W-1:0]    hl3_next [3];
    logic [2*SPLIT-1:0] ll3_next [3];
    logic [IDXF_W-1:0]  idx_full;
    logic [INDEX_W-1:0] idx3_next;
    logic               quad3_next;

    always_comb
    begin
        s3_next = S_W'(sq2_reg[0]) + S_W'(sq2_reg[1]) + S_W'(sq2_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            hh3_next[i] = (2*HI_W)'(mk2_reg[i][MK_W-1:SPLIT])
                        * (2*HI_W)'(mk2_reg[i][MK_W-1:SPLIT]);
            hl3_next[i] = MK_W'(mk2_reg[i][MK_W-1:SPLIT]) * MK_W'(mk2_reg[i][SPLIT-1:0]);
            ll3_next[i] = (2*SPLIT)'(mk2_reg[i][SPLIT-1:0])
                        * (2*SPLIT)'(mk2_reg[i][SPLIT-1:0]);
        end
        idx_full = IDXF_W'(face2_reg) * IDXF_W'(row2_reg) + IDXF_W'(vr2_reg)
                 + IDXF_W'(u2_reg);
        idx3_next  = INDEX_W'(idx_full);
        quad3_next = (u2_reg < res_eff) && (v2_reg < res_eff);
    end

    logic [S_W-1:0]     s3_reg;
    logic [2*HI_W-1:0]  hh3_reg [3];
    logic [MK_W-1:0]    hl3_reg [3];
    logic [2*SPLIT-1:0] ll3_reg [3];
    logic [DV_W-1:0]    sq3_reg [3];
    logic [2:0]         neg3_reg;
    logic [INDEX_W-1:0] idx3_reg;
    logic               quad3_reg;
    logic [DV_W-1:0]    nu3_reg;
    logic [DV_W-1:0]    nv3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg    <= s3_next;
            hh3_reg   <= hh3_next;
            hl3_reg   <= hl3_next;
            ll3_reg   <= ll3_next;
            sq3_reg   <= sq2_reg;
            neg3_reg  <= neg2_reg;
            idx3_reg  <= idx3_next;
            quad3_reg <= quad3_next;
            nu3_reg   <= nu2_reg;
            nv3_reg   <= nv2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: the square root operands. Rounding half up of
    // mag*k/sqrt(s) is ((floor(sqrt(4 mag^2 k^2 / s)) + 1) >> 1), so the
    // lanes take r = 4 mag^2 k^2 with k the radius or 2^F.
    // ------------------------------------------------------------------
    logic [RP_W-1:0] rp4_next [3];
    logic [RN_W-1:0] rn4_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rp4_next[i] = ((RP_W'(hh3_reg[i]) << (2 * SPLIT))
                        + (RP_W'(hl3_reg[i]) << (SPLIT + 1))
                        + RP_W'(ll3_reg[i])) << 2;
            rn4_next[i] = RN_W'(sq3_reg[i]) << (2 * F + 2);
        end
    end

    logic [RP_W-1:0]    rp4_reg [3];
    logic [RN_W-1:0]    rn4_reg [3];
    logic [S_W-1:0]     s4_reg;
    logic [2:0]         neg4_reg;
    logic [INDEX_W-1:0] idx4_reg;
    logic               quad4_reg;
    logic [DV_W-1:0]    nu4_reg;
    logic [DV_W-1:0]    nv4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp4_reg   <= rp4_next;
            rn4_reg   <= rn4_next;
            s4_reg    <= s3_reg;
            neg4_reg  <= neg3_reg;
            idx4_reg  <= idx3_reg;
            quad4_reg <= quad3_reg;
            nu4_reg   <= nu3_reg;
            nv4_reg   <= nv3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root lanes, one per component for position and for normal.
    // ------------------------------------------------------------------
    logic [XP_W-1:0] xp [3];
    logic [XN_W-1:0] xn [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            csv_isqrt_pipe #(
                .R_W   (RP_W),
                .S_W   (S_W),
                .X_W   (XP_W),
                .DEPTH (LD)
            ) u_pos (
                .clk (clk),
                .en  (en),
                .r   (rp4_reg[g]),
                .s   (s4_reg),
                .x   (xp[g])
            );

            csv_isqrt_pipe #(
                .R_W   (RN_W),
                .S_W   (S_W),
                .X_W   (XN_W),
                .DEPTH (LD)
            ) u_norm (
                .clk (clk),
                .en  (en),
                .r   (rn4_reg[g]),
                .s   (s4_reg),
                .x   (xn[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Side pipeline running beside the lanes: signs, index, quad flag and
    // the two cell divisions, one quotient bit per stage. The quotient is
    // at most the working grid resolution, so MAG_W bits cover it.
    // ------------------------------------------------------------------
    logic [2:0]         neg_sd_reg  [LD];
    logic [INDEX_W-1:0] idx_sd_reg  [LD];
    logic               quad_sd_reg [LD];
    logic [DV_W-1:0]    remu_sd_reg [LD];
    logic [DV_W-1:0]    remv_sd_reg [LD];
    logic [MAG_W-1:0]   qu_sd_reg   [LD];
    logic [MAG_W-1:0]   qv_sd_reg   [LD];

    generate
        for (g = 0; g < LD; g++) begin : g_side
            logic [2:0]         neg_in;
            logic [INDEX_W-1:0] idx_in;
            logic               quad_in;
            logic [DV_W-1:0]    remu_in;
            logic [DV_W-1:0]    remv_in;
            logic [MAG_W-1:0]   qu_in;
            logic [MAG_W-1:0]   qv_in;
            logic [DV_W-1:0]    remu_next;
            logic [DV_W-1:0]    remv_next;
            logic [MAG_W-1:0]   qu_next;
            logic [MAG_W-1:0]   qv_next;

            if (g == 0) begin : g_first
                assign neg_in  = neg4_reg;
                assign idx_in  = idx4_reg;
                assign quad_in = quad4_reg;
                assign remu_in = nu4_reg;
                assign remv_in = nv4_reg;
                assign qu_in   = '0;
                assign qv_in   = '0;
            end
            else begin : g_rest
                assign neg_in  = neg_sd_reg[g-1];
                assign idx_in  = idx_sd_reg[g-1];
                assign quad_in = quad_sd_reg[g-1];
                assign remu_in = remu_sd_reg[g-1];
                assign remv_in = remv_sd_reg[g-1];
                assign qu_in   = qu_sd_reg[g-1];
                assign qv_in   = qv_sd_reg[g-1];
            end

            if (g < MAG_W) begin : g_div
                localparam int B = MAG_W - 1 - g;
                logic [DV_W-1:0] dsh;

                always_comb
                begin
                    dsh = DV_W'(res_eff) << B;
                    if (remu_in >= dsh)
                    begin
                        remu_next = remu_in - dsh;
                        qu_next   = qu_in | (MAG_W'(1) << B);
                    end
                    else
                    begin
                        remu_next = remu_in;
                        qu_next   = qu_in;
                    end
                    if (remv_in >= dsh)
                    begin
                        remv_next = remv_in - dsh;
                        qv_next   = qv_in | (MAG_W'(1) << B);
                    end
                    else
                    begin
                        remv_next = remv_in;
                        qv_next   = qv_in;
                    end
                end
            end
            else begin : g_pass
                assign remu_next = remu_in;
                assign remv_next = remv_in;
                assign qu_next   = qu_in;
                assign qv_next   = qv_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_sd_reg[g]  <= neg_in;
                    idx_sd_reg[g]  <= idx_in;
                    quad_sd_reg[g] <= quad_in;
                    remu_sd_reg[g] <= remu_next;
                    remv_sd_reg[g] <= remv_next;
                    qu_sd_reg[g]   <= qu_next;
                    qv_sd_reg[g]   <= qv_next;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Final stage: round, saturate the normal, apply signs, clamp cells.
    // ------------------------------------------------------------------
    logic [XP_W-1:0]          mp [3];
    logic [XN_W-1:0]          mn [3];
    logic [XN_W-1:0]          nsat [3];
    logic signed [XP_W-1:0]   ps [3];
    logic signed [XN_W-1:0]   ns [3];
    logic signed [POS_W-1:0]  pos_next [3];
    logic signed [NORM_W-1:0] norm_next [3];
    logic [MAG_W-1:0]         gm1;
    logic [CELL_W-1:0]        cu_next;
    logic [CELL_W-1:0]        cv_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mp[i] = XP_W'(((XP_W+1)'(xp[i]) + (XP_W+1)'(1)) >> 1);
            mn[i] = XN_W'(((XN_W+1)'(xn[i]) + (XN_W+1)'(1)) >> 1);
            // A component straight along an axis gives exactly 2^F.
            nsat[i] = (mn[i] > XN_W'(NMAX)) ? XN_W'(NMAX) : mn[i];
            ps[i] = neg_sd_reg[LD-1][i] ? -$signed(mp[i]) : $signed(mp[i]);
            ns[i] = neg_sd_reg[LD-1][i] ? -$signed(nsat[i]) : $signed(nsat[i]);
            pos_next[i]  = POS_W'(ps[i]);
            norm_next[i] = NORM_W'(ns[i]);
        end
        gm1 = grid_eff - MAG_W'(1);
        cu_next = CELL_W'((qu_sd_reg[LD-1] > gm1) ? gm1 : qu_sd_reg[LD-1]);
        cv_next = CELL_W'((qv_sd_reg[LD-1] > gm1) ? gm1 : qv_sd_reg[LD-1]);
    end

    // Output register.
    logic signed [POS_W-1:0]  pos_reg [3];
    logic signed [NORM_W-1:0] norm_reg [3];
    logic [CELL_W-1:0]        cu_reg;
    logic [CELL_W-1:0]        cv_reg;
    logic [INDEX_W-1:0]       idx_out_reg;
    logic                     quad_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg      <= pos_next;
            norm_reg     <= norm_next;
            cu_reg       <= cu_next;
            cv_reg       <= cv_next;
            idx_out_reg  <= idx_sd_reg[LD-1];
            quad_out_reg <= quad_sd_reg[LD-1];
        end
    end

    assign vertex.valid        = vld_reg[TOT-1];
    assign vertex.pos_x        = pos_reg[0];
    assign vertex.pos_y        = pos_reg[1];
    assign vertex.pos_z        = pos_reg[2];
    assign vertex.normal_x     = norm_reg[0];
    assign vertex.normal_y     = norm_reg[1];
    assign vertex.normal_z     = norm_reg[2];
    assign vertex.cell_u       = cu_reg;
    assign vertex.cell_v       = cv_reg;
    assign vertex.vertex_index = idx_out_reg;
    assign vertex.quad_corner  = quad_out_reg;

`ifndef SYNTH
    // A stalled pipeline must neither drop nor create items.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved while the pipeline was stalled");

    // Cells are always clamped below the working grid resolution.
    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid |-> (int'(vertex.cell_u) < int'(grid_eff))
                      && (int'(vertex.cell_v) < int'(grid_eff)))
        else $error("cell number at or above the grid resolution");
`endif

endmodule
